// ===== src/dats_pkg.sv =====
// dats_pkg: shared types and constants of the daily alarm table scheduler.
// Used by the controller, the datapath and the local time divider.
package dats_pkg;

    // field widths
    localparam int FUNC_W    = 3;
    localparam int EPOCH_W   = 40;
    localparam int IDX_W     = 3;
    localparam int MINUTE_W  = 11;
    localparam int SERV_W    = 4;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = 4;
    localparam int TZ_W      = 11;
    localparam int DAY_W     = 24;

    // offset in seconds: +-840*60 fits 17 bits signed
    localparam int TZSEC_W   = 17;
    // clamped local seconds: below 2^41
    localparam int LOCAL_W   = 41;
    // remainder of seconds modulo one day
    localparam int REM_W     = 17;
    // quotient bits retired per divider cycle
    localparam int DIV_RB    = 4;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SYNC   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CHANGE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;

    // completion status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_MINUTE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_SERV    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EARLY_EPOCH = 3'd5;

    // result kinds
    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_FIRED = 1'b1;

    localparam logic [EPOCH_W-1:0]     MIN_EPOCH   = 40'd1577836800;
    localparam logic [REM_W:0]         DAY_SECONDS = 18'd86400;
    localparam logic [MINUTE_W-1:0]    DAY_MINUTES = 11'd1440;
    localparam logic signed [TZ_W-1:0] MAX_TZ      = 11'sd840;
    localparam logic signed [TZSEC_W-1:0] SEC_PER_MIN = 17'sd60;

    // floor(r / 60) = (r * RECIP_60) >> RECIP_SHIFT, exact for r < 161319
    localparam logic [17:0] RECIP_60    = 18'd139811;
    localparam int          RECIP_SHIFT = 23;

    typedef struct packed {
        logic [MINUTE_W-1:0] minute;
        logic [SERV_W-1:0]   servings;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic latch_status;
        logic clock_set;
        logic wr_edit;
        logic res_edit;
        logic size_inc;
        logic size_dec;
        logic div_start;
        logic ptr_zero;
        logic ptr_slot;
        logic ptr_inc;
        logic rd_next;
        logic wr_fire;
        logic out_fire;
        logic res_removed;
        logic wr_shift;
        logic out_done;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_tick;
        logic op_sync;
        logic op_add;
        logic op_change;
        logic op_delete;
        logic err;
        logic clock_valid;
        logic size_zero;
        logic more;
        logic due;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ===== src/dats_div.sv =====
// dats_div: local day and minute of day from UTC seconds and zone offset.
// Restoring division by 86400, DIV_RB quotient bits per cycle, then a
// reciprocal multiply for the minute. Depends on dats_pkg.
module dats_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [dats_pkg::EPOCH_W-1:0]          epoch,
    input  logic signed [dats_pkg::TZSEC_W-1:0]   offset_sec,
    output logic                                  done,
    output logic [dats_pkg::DAY_W-1:0]            day,
    output logic [dats_pkg::MINUTE_W-1:0]         minute
);

    localparam int STEPS  = (dats_pkg::LOCAL_W + dats_pkg::DIV_RB - 1) / dats_pkg::DIV_RB;
    localparam int PAD_W  = STEPS * dats_pkg::DIV_RB;
    localparam int SCNT_W = $clog2(STEPS + 1);
    localparam int PROD_W = dats_pkg::REM_W + 18;

    logic [PAD_W-1:0]                num_reg;
    logic [dats_pkg::REM_W-1:0]      rem_reg;
    logic [dats_pkg::DAY_W-1:0]      quot_reg;
    logic [SCNT_W-1:0]               cnt_reg;
    logic                            busy_reg;
    logic                            mul_reg;
    logic                            done_reg;
    logic [dats_pkg::MINUTE_W-1:0]   minute_reg;

    logic signed [dats_pkg::LOCAL_W:0] local_s;
    logic [dats_pkg::LOCAL_W-1:0]      local_u;
    logic [dats_pkg::REM_W-1:0]        rem_v;
    logic [dats_pkg::DAY_W-1:0]        quot_v;
    logic [PROD_W-1:0]                 prod;

    always_comb begin
        local_s = $signed({2'b00, epoch}) + (dats_pkg::LOCAL_W + 1)'(offset_sec);
        // local time before 1970 counts as zero
        local_u = local_s[dats_pkg::LOCAL_W] ? '0 : local_s[dats_pkg::LOCAL_W-1:0];
    end

    always_comb begin
        logic [dats_pkg::REM_W:0] trial;
        logic                     qbit;
        rem_v  = rem_reg;
        quot_v = quot_reg;
        for (int k = 0; k < dats_pkg::DIV_RB; k++) begin
            trial = {rem_v, num_reg[PAD_W-1-k]};
            if (trial >= dats_pkg::DAY_SECONDS) begin
                trial = trial - dats_pkg::DAY_SECONDS;
                qbit  = 1'b1;
            end else begin
                qbit  = 1'b0;
            end
            rem_v  = trial[dats_pkg::REM_W-1:0];
            quot_v = {quot_v[dats_pkg::DAY_W-2:0], qbit};
        end
    end

    assign prod = PROD_W'(rem_reg) * PROD_W'(dats_pkg::RECIP_60);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= mul_reg;
            mul_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == SCNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    mul_reg  <= 1'b1;
                end
                cnt_reg <= cnt_reg + SCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= PAD_W'(local_u);
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            num_reg  <= num_reg << dats_pkg::DIV_RB;
            rem_reg  <= rem_v;
            quot_reg <= quot_v;
        end
        if (mul_reg) begin
            minute_reg <= prod[dats_pkg::RECIP_SHIFT +: dats_pkg::MINUTE_W];
        end
    end

    assign done   = done_reg;
    assign day    = quot_reg;
    assign minute = minute_reg;

endmodule

// ===== src/dats_dp.sv =====
// dats_dp: alarm table memories, item capture, checks, result register and
// config register. Driven by dats_ctrl; uses dats_div. Depends on dats_pkg.
module dats_dp #(
    parameter int TABLE_DEPTH  = 8,
    parameter int MAX_SERVINGS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [63:0]                       s_tdata,
    input  logic [dats_pkg::FUNC_W-1:0]       s_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dats_pkg::TZ_W-1:0]         cfg_data,
    input  dats_pkg::cmd_t                    cmd,
    output dats_pkg::stat_t                   stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = CW + 3;

    // table storage; never-written rows are don't-care
    dats_pkg::entry_t             mc_mem  [TABLE_DEPTH];
    logic [dats_pkg::DAY_W-1:0]   day_mem [TABLE_DEPTH];
    dats_pkg::entry_t             mc_rd_reg;
    logic [dats_pkg::DAY_W-1:0]   day_rd_reg;

    logic [TABLE_DEPTH-1:0]       known_reg;
    logic [CW-1:0]                size_reg;
    logic                         clock_valid_reg;
    logic signed [dats_pkg::TZSEC_W-1:0] tz_sec_reg;
    logic [CW-1:0]                ptr_reg;

    // captured item
    logic [dats_pkg::FUNC_W-1:0]   func_reg;
    logic [dats_pkg::EPOCH_W-1:0]  epoch_reg;
    logic [dats_pkg::IDX_W-1:0]    slot_reg;
    logic [dats_pkg::MINUTE_W-1:0] minute_req_reg;
    logic [dats_pkg::SERV_W-1:0]   serv_req_reg;

    // completion fields
    logic [dats_pkg::STATUS_W-1:0] res_status_reg;
    logic [dats_pkg::IDX_W-1:0]    res_idx_reg;
    logic [dats_pkg::SERV_W-1:0]   res_serv_reg;
    logic [dats_pkg::MINUTE_W-1:0] res_min_reg;

    // output register
    logic                          m_tvalid_reg;
    logic                          o_kind_reg;
    logic [dats_pkg::STATUS_W-1:0] o_status_reg;
    logic [dats_pkg::IDX_W-1:0]    o_idx_reg;
    logic [dats_pkg::SERV_W-1:0]   o_serv_reg;
    logic [dats_pkg::MINUTE_W-1:0] o_min_reg;
    logic [dats_pkg::CNT_W-1:0]    o_cnt_reg;
    logic                          o_last_reg;

    logic [dats_pkg::STATUS_W-1:0] err_status;
    logic [XW-1:0]                 slot_ext;
    logic [XW-1:0]                 size_ext;
    logic [XW-1:0]                 ptr_ext;
    logic [CW+3:0]                 size_cnt_ext;
    logic [CW:0]                   ptr_p1;
    logic [AW-1:0]                 ptr_idx;
    logic [AW-1:0]                 ptr_p1_idx;
    logic [AW-1:0]                 edit_addr;
    logic [AW+2:0]                 edit_ext;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic                          mc_we;
    logic                          day_we;
    dats_pkg::entry_t              mc_wdata;
    logic [dats_pkg::DAY_W-1:0]    day_wdata;
    logic                          serv_bad;
    logic                          index_bad;
    logic                          is_add;
    logic                          out_free;
    logic signed [dats_pkg::TZ_W-1:0] tz_sat;
    logic signed [dats_pkg::TZ_W-1:0] cfg_s;

    logic                          div_done;
    logic [dats_pkg::DAY_W-1:0]    div_day;
    logic [dats_pkg::MINUTE_W-1:0] div_minute;

    dats_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.div_start),
        .epoch      (epoch_reg),
        .offset_sec (tz_sec_reg),
        .done       (div_done),
        .day        (div_day),
        .minute     (div_minute)
    );

    assign slot_ext     = {{CW{1'b0}}, slot_reg};
    assign size_ext     = {3'b000, size_reg};
    assign ptr_ext      = {3'b000, ptr_reg};
    assign size_cnt_ext = {4'b0000, size_reg};
    assign ptr_p1       = {1'b0, ptr_reg} + (CW + 1)'(1);
    assign ptr_idx      = ptr_reg[AW-1:0];
    assign ptr_p1_idx   = ptr_p1[AW-1:0];
    assign is_add       = (func_reg == dats_pkg::FUNC_ADD);
    assign edit_addr    = is_add ? size_reg[AW-1:0] : slot_ext[AW-1:0];
    assign edit_ext     = {3'b000, edit_addr};
    assign rd_addr      = cmd.rd_next ? ptr_p1_idx : ptr_idx;
    assign wr_addr      = cmd.wr_edit ? edit_addr : ptr_idx;
    assign out_free     = !m_tvalid_reg || m_tready;
    assign serv_bad     = (serv_req_reg == '0) ||
                          (serv_req_reg > dats_pkg::SERV_W'(MAX_SERVINGS));
    assign index_bad    = (slot_ext >= size_ext);

    always_comb begin
        err_status = dats_pkg::ST_OK;
        case (func_reg)
            dats_pkg::FUNC_SYNC: begin
                if (epoch_reg < dats_pkg::MIN_EPOCH) err_status = dats_pkg::ST_EARLY_EPOCH;
            end
            dats_pkg::FUNC_ADD: begin
                if (size_reg >= CW'(TABLE_DEPTH))                 err_status = dats_pkg::ST_FULL;
                else if (minute_req_reg >= dats_pkg::DAY_MINUTES) err_status = dats_pkg::ST_BAD_MINUTE;
                else if (serv_bad)                                err_status = dats_pkg::ST_BAD_SERV;
            end
            dats_pkg::FUNC_CHANGE: begin
                if (index_bad)                                    err_status = dats_pkg::ST_BAD_INDEX;
                else if (minute_req_reg >= dats_pkg::DAY_MINUTES) err_status = dats_pkg::ST_BAD_MINUTE;
                else if (serv_bad)                                err_status = dats_pkg::ST_BAD_SERV;
            end
            dats_pkg::FUNC_DELETE: begin
                if (index_bad) err_status = dats_pkg::ST_BAD_INDEX;
            end
            default: err_status = dats_pkg::ST_OK;
        endcase
    end

    // memory write port
    always_comb begin
        mc_we     = cmd.wr_edit || cmd.wr_shift;
        day_we    = cmd.wr_fire || cmd.wr_shift;
        mc_wdata  = cmd.wr_edit ? dats_pkg::entry_t'({minute_req_reg, serv_req_reg}) : mc_rd_reg;
        day_wdata = cmd.wr_fire ? div_day : day_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (mc_we)  mc_mem[wr_addr]  <= mc_wdata;
        if (day_we) day_mem[wr_addr] <= day_wdata;
        mc_rd_reg  <= mc_mem[rd_addr];
        day_rd_reg <= day_mem[rd_addr];
    end

    // config: saturate to +-840 minutes, keep as seconds
    always_comb begin
        cfg_s = $signed(cfg_data);
        if (cfg_s > dats_pkg::MAX_TZ)       tz_sat = dats_pkg::MAX_TZ;
        else if (cfg_s < -dats_pkg::MAX_TZ) tz_sat = -dats_pkg::MAX_TZ;
        else                                tz_sat = cfg_s;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            known_reg       <= '0;
            size_reg        <= '0;
            clock_valid_reg <= 1'b0;
            tz_sec_reg      <= '0;
            ptr_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) tz_sec_reg <= dats_pkg::TZSEC_W'(tz_sat) * dats_pkg::SEC_PER_MIN;
            if (cmd.clock_set) clock_valid_reg <= 1'b1;
            if (cmd.wr_edit && is_add) known_reg[edit_addr] <= 1'b0;
            if (cmd.wr_fire)  known_reg[ptr_idx] <= 1'b1;
            if (cmd.wr_shift) known_reg[ptr_idx] <= known_reg[ptr_p1_idx];
            if (cmd.size_inc) size_reg <= size_reg + CW'(1);
            if (cmd.size_dec) size_reg <= size_reg - CW'(1);
            if (cmd.ptr_zero)      ptr_reg <= '0;
            else if (cmd.ptr_slot) ptr_reg <= slot_ext[CW-1:0];
            else if (cmd.ptr_inc)  ptr_reg <= ptr_p1[CW-1:0];
            if (cmd.out_fire || cmd.out_done) m_tvalid_reg <= 1'b1;
            else if (m_tready)                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg       <= s_tuser;
            epoch_reg      <= s_tdata[39:0];
            slot_reg       <= s_tdata[42:40];
            minute_req_reg <= s_tdata[53:43];
            serv_req_reg   <= s_tdata[57:54];
            res_status_reg <= dats_pkg::ST_OK;
            res_idx_reg    <= '0;
            res_serv_reg   <= '0;
            res_min_reg    <= '0;
        end
        if (cmd.latch_status) res_status_reg <= err_status;
        if (cmd.res_edit) begin
            res_idx_reg  <= edit_ext[dats_pkg::IDX_W-1:0];
            res_serv_reg <= serv_req_reg;
            res_min_reg  <= minute_req_reg;
        end
        if (cmd.res_removed) begin
            res_idx_reg  <= slot_reg;
            res_serv_reg <= mc_rd_reg.servings;
            res_min_reg  <= mc_rd_reg.minute;
        end
        if (cmd.out_fire) begin
            o_kind_reg   <= dats_pkg::KIND_FIRED;
            o_status_reg <= dats_pkg::ST_OK;
            o_idx_reg    <= ptr_ext[dats_pkg::IDX_W-1:0];
            o_serv_reg   <= mc_rd_reg.servings;
            o_min_reg    <= mc_rd_reg.minute;
            o_cnt_reg    <= size_cnt_ext[dats_pkg::CNT_W-1:0];
            o_last_reg   <= 1'b0;
        end else if (cmd.out_done) begin
            o_kind_reg   <= dats_pkg::KIND_DONE;
            o_status_reg <= res_status_reg;
            o_idx_reg    <= res_idx_reg;
            o_serv_reg   <= res_serv_reg;
            o_min_reg    <= res_min_reg;
            o_cnt_reg    <= size_cnt_ext[dats_pkg::CNT_W-1:0];
            o_last_reg   <= 1'b1;
        end
    end

    always_comb begin
        stat.op_tick     = (func_reg == dats_pkg::FUNC_TICK);
        stat.op_sync     = (func_reg == dats_pkg::FUNC_SYNC);
        stat.op_add      = is_add;
        stat.op_change   = (func_reg == dats_pkg::FUNC_CHANGE);
        stat.op_delete   = (func_reg == dats_pkg::FUNC_DELETE);
        stat.err         = (err_status != dats_pkg::ST_OK);
        stat.clock_valid = clock_valid_reg;
        stat.size_zero   = (size_reg == '0);
        stat.more        = (ptr_p1 < {1'b0, size_reg});
        // fire when never fired (or fired on an earlier day, tick only)
        // and the alarm minute has come
        stat.due         = (!known_reg[ptr_idx] ||
                            ((func_reg == dats_pkg::FUNC_TICK) && (day_rd_reg < div_day))) &&
                           (div_minute >= mc_rd_reg.minute);
        stat.div_done    = div_done;
        stat.out_free    = out_free;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0000000, o_cnt_reg, o_min_reg, o_serv_reg, o_idx_reg, o_status_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

endmodule

// ===== src/dats_ctrl.sv =====
// dats_ctrl: sequencer of the alarm scheduler. Decodes each item, runs the
// table edit, local time, scan and compaction steps. Depends on dats_pkg.
module dats_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  dats_pkg::stat_t  stat,
    output dats_pkg::cmd_t   cmd
);

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_DECODE    = 14'b00000000000010,
        S_EDIT      = 14'b00000000000100,
        S_DIV_START = 14'b00000000001000,
        S_DIV_WAIT  = 14'b00000000010000,
        S_SCAN_RD   = 14'b00000000100000,
        S_SCAN_EV   = 14'b00000001000000,
        S_DEL_RD    = 14'b00000010000000,
        S_DEL_CAP   = 14'b00000100000000,
        S_DEL_CHK   = 14'b00001000000000,
        S_SHIFT_RD  = 14'b00010000000000,
        S_SHIFT_WR  = 14'b00100000000000,
        S_DEL_END   = 14'b01000000000000,
        S_COMPLETE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.latch_status = 1'b1;
                cmd.ptr_slot     = 1'b1;
                if (stat.err) begin
                    state_next = S_COMPLETE;
                end else if (stat.op_tick) begin
                    state_next = stat.clock_valid ? S_DIV_START : S_COMPLETE;
                end else if (stat.op_sync) begin
                    cmd.clock_set = 1'b1;
                    state_next    = S_DIV_START;
                end else if (stat.op_add || stat.op_change) begin
                    state_next = S_EDIT;
                end else if (stat.op_delete) begin
                    state_next = S_DEL_RD;
                end else begin
                    state_next = S_COMPLETE;
                end
            end
            S_EDIT: begin
                cmd.wr_edit  = 1'b1;
                cmd.res_edit = 1'b1;
                cmd.size_inc = stat.op_add;
                state_next   = stat.clock_valid ? S_DIV_START : S_COMPLETE;
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
                cmd.ptr_zero  = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = stat.size_zero ? S_COMPLETE : S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                // a firing tick holds here until the output register frees up
                if (!(stat.due && stat.op_tick && !stat.out_free)) begin
                    if (stat.due) begin
                        cmd.wr_fire  = 1'b1;
                        cmd.out_fire = stat.op_tick;
                    end
                    if (stat.more) begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = S_SCAN_RD;
                    end else begin
                        state_next  = S_COMPLETE;
                    end
                end
            end
            S_DEL_RD: begin
                state_next = S_DEL_CAP;
            end
            S_DEL_CAP: begin
                cmd.res_removed = 1'b1;
                state_next      = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                state_next = stat.more ? S_SHIFT_RD : S_DEL_END;
            end
            S_SHIFT_RD: begin
                cmd.rd_next = 1'b1;
                state_next  = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_inc  = 1'b1;
                state_next   = S_DEL_CHK;
            end
            S_DEL_END: begin
                cmd.size_dec = 1'b1;
                state_next   = S_COMPLETE;
            end
            S_COMPLETE: begin
                if (stat.out_free) begin
                    cmd.out_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/daily_alarm_table_scheduler_top.sv =====
// daily_alarm_table_scheduler_top: table of daily alarms with tick, clock sync,
// add, change and delete. Depends on dats_pkg, dats_ctrl, dats_dp, dats_div.
// Input beats on s_*: one item each, func in s_tuser. Output beats on m_*: a
// tick gives one fired beat (tuser 1) per due alarm in table order, and every
// item ends with one completion beat (tuser 0, tlast 1). cfg_* writes the
// zone offset in minutes; it is always ready. The user must write it only
// while idle; the block does not enforce this. One item is processed at a
// time; s_tready is high only while idle. Items that need local time run the
// divider (4 quotient bits per cycle over 41 bits, then a reciprocal multiply)
// and then scan the table entries in order; a delete moves each later entry up.
// The output register frees the core: a result may wait on m_tready while
// the next item is accepted; a stalled receiver holds the core only when it
// has a new beat to hand over. Reset empties the table, clears the clock-
// valid flag and sets the offset to zero; no clearing pass is needed.
module daily_alarm_table_scheduler_top #(
    parameter int TABLE_DEPTH  = 8,
    parameter int MAX_SERVINGS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [39:0] epoch_seconds, [42:40] slot_index, [53:43] alarm_minute,
    // [57:54] alarm_servings, [63:58] zero
    input  logic [63:0] s_tdata,
    // [2:0] func
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [5:3] entry_index, [9:6] entry_servings,
    // [20:10] entry_minute, [24:21] entry_count, [31:25] zero
    output logic [31:0] m_tdata,
    // [0] result_kind
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    dats_pkg::cmd_t  cmd;
    dats_pkg::stat_t stat;

    dats_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dats_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_SERVINGS (MAX_SERVINGS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== src/dats_checker.sv =====
// dats_checker: port-level checks of the alarm scheduler, bound to the top.
// Depends on the top level's ports and the status codes in dats_pkg.
module dats_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("output beat changed while stalled");

    // one item at a time: ready drops after an accepted beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // fired beats are never last and always carry ok status
    a_fired_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast && (m_tdata[2:0] == dats_pkg::ST_OK))
        else $error("fired beat with tlast or non-zero status");

    // error completions carry zero entry fields
    a_err_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != dats_pkg::ST_OK) |-> m_tlast && (m_tdata[20:3] == 18'd0))
        else $error("error completion with entry fields set");

endmodule

bind daily_alarm_table_scheduler_top dats_checker u_dats_checker (.*);
